@@ hdl/clamped_pid_speed_loop_top_assert.svh @@
// Assertion macros for the clamped PID speed loop.
// Expect clk and rst_n in the including scope.
`ifndef CLAMPED_PID_SPEED_LOOP_TOP_ASSERT_SVH
`define CLAMPED_PID_SPEED_LOOP_TOP_ASSERT_SVH

// same-cycle implication
`define CPSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cpsl assertion failed");

// next-cycle implication
`define CPSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cpsl assertion failed");

`endif

@@ hdl/cpsl_pkg.sv @@
// Shared types and constants for the clamped PID speed loop.
// No dependencies.
package cpsl_pkg;

    localparam int SPEED_W       = 16;
    localparam int ERR_W         = 17;
    localparam int GAIN_W        = 16;
    localparam int LIMIT_W       = 15;
    localparam int CHAN_W        = 2;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 16;
    localparam int CPSL_CHANNELS = 4;

    localparam logic [LIMIT_W-1:0] OUTPUT_LIMIT_RST = 15'd16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_P         = 3'd0,
        CFG_GAIN_I         = 3'd1,
        CFG_GAIN_D         = 3'd2,
        CFG_INTEGRAL_LIMIT = 3'd3,
        CFG_OUTPUT_LIMIT   = 3'd4
    } cfg_idx_t;

    // per-channel loop state
    typedef struct packed {
        logic signed [SPEED_W-1:0] integral;
        logic signed [ERR_W-1:0]   prev_error;
    } cpsl_state_t;

endpackage

@@ hdl/clamped_pid_speed_loop_top.sv @@
// Pipeline: input register, then result register driving out_valid; a stall holds both.
// Throughput: one item per cycle when out_ready does not stall; the channel state is read
// and written in the same cycle as the compute step, so consecutive items on one channel
// chain directly.
// Reset: async active low; gains and integral limit clear to 0, output limit
// to 16384, all channel integrals and previous errors to 0.
`include "clamped_pid_speed_loop_top_assert.svh"

module clamped_pid_speed_loop_top
    import cpsl_pkg::*;
#(
    parameter int CHANNELS = CPSL_CHANNELS
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [CHAN_W-1:0]         channel,
    input  logic signed [SPEED_W-1:0] measured,
    input  logic signed [SPEED_W-1:0] target,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic signed [SPEED_W-1:0] drive
);

    logic signed [GAIN_W-1:0]  gain_p_reg;
    logic signed [GAIN_W-1:0]  gain_i_reg;
    logic signed [GAIN_W-1:0]  gain_d_reg;
    logic [LIMIT_W-1:0]        integral_limit_reg;
    logic [LIMIT_W-1:0]        output_limit_reg;

    logic                      s1_valid_reg;
    logic [CHAN_W-1:0]         channel_reg;
    logic signed [SPEED_W-1:0] measured_reg;
    logic signed [SPEED_W-1:0] target_reg;

    logic                      out_valid_reg;
    logic signed [SPEED_W-1:0] drive_reg;

    logic                      s1_adv;
    logic                      hit;
    cpsl_state_t               cur_state;
    cpsl_state_t               upd_state;
    logic signed [SPEED_W-1:0] drive_next;

    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign out_valid = out_valid_reg;
    assign drive     = drive_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= '0;
            gain_i_reg         <= '0;
            gain_d_reg         <= '0;
            integral_limit_reg <= '0;
            output_limit_reg   <= OUTPUT_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_GAIN_P:         gain_p_reg         <= cfg_data;
                CFG_GAIN_I:         gain_i_reg         <= cfg_data;
                CFG_GAIN_D:         gain_d_reg         <= cfg_data;
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[LIMIT_W-1:0];
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[LIMIT_W-1:0];
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            channel_reg  <= channel;
            measured_reg <= measured;
            target_reg   <= target;
        end
        if (s1_adv)
        begin
            drive_reg <= drive_next;
        end
    end

    cpsl_chan_state #(
        .CHANNELS (CHANNELS)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .channel (channel_reg),
        .wr_en   (s1_adv),
        .wr_data (upd_state),
        .rd_data (cur_state),
        .hit     (hit)
    );

    cpsl_calc u_calc (
        .measured       (measured_reg),
        .target         (target_reg),
        .gain_p         (gain_p_reg),
        .gain_i         (gain_i_reg),
        .gain_d         (gain_d_reg),
        .integral_limit (integral_limit_reg),
        .output_limit   (output_limit_reg),
        .hit            (hit),
        .cur            (cur_state),
        .upd            (upd_state),
        .drive          (drive_next)
    );

    `CPSL_ASSERT_NEXT(a_stage_holds, s1_valid_reg && out_valid_reg && !out_ready, s1_valid_reg)
    `CPSL_ASSERT_NEXT(a_absent_zero, s1_adv && !hit, out_valid_reg && drive_reg == 16'sd0)
    `CPSL_ASSERT_NOW(a_integ_range, s1_valid_reg, upd_state.integral != 16'sh8000)
    `CPSL_ASSERT_NOW(a_drive_range, out_valid_reg, drive_reg != 16'sh8000)

endmodule

@@ hdl/cpsl_chan_state.sv @@
// Per-channel integral and previous-error registers with channel select.
// Depends on cpsl_pkg.
module cpsl_chan_state
    import cpsl_pkg::*;
#(
    parameter int CHANNELS = CPSL_CHANNELS
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [CHAN_W-1:0] channel,
    input  logic              wr_en,
    input  cpsl_state_t       wr_data,
    output cpsl_state_t       rd_data,
    output logic              hit
);

    cpsl_state_t state_reg [CHANNELS];

    assign hit = int'(channel) < CHANNELS;

    always_comb
    begin
        rd_data = '0;
        for (int k = 0; k < CHANNELS; k++)
        begin
            if (int'(channel) == k)
            begin
                rd_data = state_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                state_reg[k] <= '0;
            end
        end
        else if (wr_en && hit)
        begin
            for (int k = 0; k < CHANNELS; k++)
            begin
                if (int'(channel) == k)
                begin
                    state_reg[k] <= wr_data;
                end
            end
        end
    end

endmodule

@@ hdl/cpsl_calc.sv @@
// PID arithmetic: error, P/I/D terms from Q8.8 gains with floor shift, both clamps.
// Depends on cpsl_pkg.
module cpsl_calc
    import cpsl_pkg::*;
(
    input  logic signed [SPEED_W-1:0] measured,
    input  logic signed [SPEED_W-1:0] target,
    input  logic signed [GAIN_W-1:0]  gain_p,
    input  logic signed [GAIN_W-1:0]  gain_i,
    input  logic signed [GAIN_W-1:0]  gain_d,
    input  logic [LIMIT_W-1:0]        integral_limit,
    input  logic [LIMIT_W-1:0]        output_limit,
    input  logic                      hit,
    input  cpsl_state_t               cur,
    output cpsl_state_t               upd,
    output logic signed [SPEED_W-1:0] drive
);

    logic signed [ERR_W-1:0] err;
    logic signed [32:0]      prod_p;
    logic signed [32:0]      prod_i;
    logic signed [17:0]      diff;
    logic signed [33:0]      prod_d;
    logic signed [24:0]      p_term;
    logic signed [24:0]      i_term;
    logic signed [25:0]      d_term;
    logic signed [25:0]      integ_raw;
    logic signed [25:0]      lim_i;
    logic signed [25:0]      integ_c;
    logic signed [27:0]      sum_raw;
    logic signed [27:0]      lim_o;
    logic signed [27:0]      sum_c;

    always_comb
    begin
        err    = ERR_W'(target) - ERR_W'(measured);
        prod_p = 33'(gain_p) * 33'(err);
        prod_i = 33'(gain_i) * 33'(err);
        diff   = 18'(err) - 18'(cur.prev_error);
        prod_d = 34'(gain_d) * 34'(diff);
        p_term = 25'(prod_p >>> 8);
        i_term = 25'(prod_i >>> 8);
        d_term = 26'(prod_d >>> 8);

        integ_raw = 26'(cur.integral) + 26'(i_term);
        lim_i     = 26'($signed({1'b0, integral_limit}));
        if (integ_raw > lim_i)
        begin
            integ_c = lim_i;
        end
        else if (integ_raw < -lim_i)
        begin
            integ_c = -lim_i;
        end
        else
        begin
            integ_c = integ_raw;
        end

        upd.integral   = SPEED_W'(integ_c);
        upd.prev_error = err;

        sum_raw = 28'(p_term) + 28'(upd.integral) + 28'(d_term);
        lim_o   = 28'($signed({1'b0, output_limit}));
        if (sum_raw > lim_o)
        begin
            sum_c = lim_o;
        end
        else if (sum_raw < -lim_o)
        begin
            sum_c = -lim_o;
        end
        else
        begin
            sum_c = sum_raw;
        end

        // absent channel gives zero drive
        drive = hit ? SPEED_W'(sum_c) : '0;
    end

endmodule
